@@ design/tts_pkg.sv @@
// Shared constants and types of the temporal three-tap smoother
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;

   // Sizes of the frame stores and the sample path
   localparam int MAX_FRAME_PIXELS = 4096;
   localparam int SAMPLE_BITS      = 16;
   localparam int MAX_FRAMES       = 256;
   localparam int PIX_BITS         = $clog2(MAX_FRAME_PIXELS);
   localparam int FRAME_BITS       = $clog2(MAX_FRAMES);

   // Configuration register widths
   localparam int WEIGHT_BITS = 16;
   localparam int PPF_BITS    = 13;
   localparam int FPC_BITS    = 9;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Fixed-point constants: unity in Q1.15 and the rounding bias of the product
   localparam logic [WEIGHT_BITS-1:0] ONE_Q15 = 16'd32768;
   localparam int PROD_A_BITS = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int PROD_B_BITS = SAMPLE_BITS + WEIGHT_BITS + 2;
   localparam int ACC_BITS    = SAMPLE_BITS + WEIGHT_BITS + 3;

   // Result queue depth, one entry per item that yields beats
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [PIX_BITS-1:0]   pixel_type;

   // Register indexes of the configuration port
   localparam csr_index_type CSR_SMOOTH_WEIGHT    = 2'd0;
   localparam csr_index_type CSR_PIXELS_PER_FRAME = 2'd1;
   localparam csr_index_type CSR_FRAMES_PER_CLIP  = 2'd2;

   // One queued item: an optional delayed sample and an optional raw last sample
   typedef struct packed {
      logic       has_first;
      logic       has_last;
      sample_type first_sample;
      frame_type  first_frame;
      sample_type last_sample;
      frame_type  last_frame;
   } entry_type;

endpackage
`default_nettype wire

@@ design/tts_req_if.sv @@
// Input channel: one video sample per beat
`timescale 1ns / 1ps
`default_nettype none
interface tts_req_if;
   import tts_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;
   logic       clip_start;

   modport source (output valid, output sample_in, output clip_start, input ready);
   modport sink   (input valid, input sample_in, input clip_start, output ready);
endinterface
`default_nettype wire

@@ design/tts_rsp_if.sv @@
// Result channel: one filtered or passed-through sample per beat
`timescale 1ns / 1ps
`default_nettype none
interface tts_rsp_if;
   import tts_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_out;
   frame_type  out_frame;
   logic       run_last;

   modport source (output valid, output sample_out, output out_frame, output run_last,
                   input ready);
   modport sink   (input valid, input sample_out, input out_frame, input run_last,
                   output ready);
endinterface
`default_nettype wire

@@ design/tts_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module tts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ design/temporal_three_tap_smoother.sv @@
// Temporal three-tap smoother: top level with frame stores and result queue
//
// Usage: samples enter on req in frame order, pixels_per_frame per frame and
// frames_per_clip per clip; clip_start restarts the counters at frame 0.
// Each inner-frame sample leaves as (1-s)*cur + s*(prev+next)/2 at the same
// pixel, rounded to nearest; first and last frames pass through unchanged.
// Output runs one frame behind: a first-frame beat yields nothing unless it is
// also last; a last-frame beat yields the delayed sample, if any, then the raw sample.
// A result passes through stage 1, stage 2 and the result queue to reach rsp.
// Throughput: one input beat per cycle while the result queue has room; on the
// last frame rsp carries two beats per input, so the queue can fill and hold input back.
// Both frame stores are read at accept and written back from stage 1;
// back-to-back hits on the same pixel are forwarded from the write stage.
// On a rsp stall the eight-entry result queue plus items in flight fills, then req.ready drops.
// Reset: counters to zero, registers to weight 3277, 4096 pixels, 16 frames;
// store contents stay undefined and are used only after being written.
// Configuration: csr_* writes, one register per beat, while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module temporal_three_tap_smoother (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tts_req_if.sink                     req,
   tts_rsp_if.source                   rsp,
   input  wire logic                   csr_write_en,
   input  wire tts_pkg::csr_index_type csr_index,
   input  wire tts_pkg::csr_data_type  csr_data
);
   import tts_pkg::*;

   // Configuration registers
   logic [WEIGHT_BITS-1:0] weight_ff;
   logic [PPF_BITS-1:0]    ppf_ff;
   logic [FPC_BITS-1:0]    fpc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 16'd3277;
         ppf_ff    <= 13'd4096;
         fpc_ff    <= 9'd16;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SMOOTH_WEIGHT:    weight_ff <= csr_data;
            CSR_PIXELS_PER_FRAME: ppf_ff    <= csr_data[PPF_BITS-1:0];
            CSR_FRAMES_PER_CLIP:  fpc_ff    <= csr_data[FPC_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers into range
   logic [WEIGHT_BITS-1:0] weight_eff;
   logic [WEIGHT_BITS-1:0] weight_inv;
   pixel_type              pix_max;
   frame_type              frame_max;

   always_comb begin
      weight_eff = (weight_ff > ONE_Q15) ? ONE_Q15 : weight_ff;
      weight_inv = ONE_Q15 - weight_eff;
      if (ppf_ff == '0) begin
         pix_max = '0;
      end else if (ppf_ff > PPF_BITS'(MAX_FRAME_PIXELS)) begin
         pix_max = PIX_BITS'(MAX_FRAME_PIXELS - 1);
      end else begin
         pix_max = PIX_BITS'(ppf_ff - 1'b1);
      end
      if (fpc_ff == '0) begin
         frame_max = '0;
      end else if (fpc_ff > FPC_BITS'(MAX_FRAMES)) begin
         frame_max = FRAME_BITS'(MAX_FRAMES - 1);
      end else begin
         frame_max = FRAME_BITS'(fpc_ff - 1'b1);
      end
   end

   // Stage 1 and stage 2 registers, result queue state
   logic       s1_valid_ff, s1_valid_in;
   pixel_type  s1_addr_ff;
   sample_type s1_sample_ff;
   frame_type  s1_frame_ff;
   logic       s1_first_ff, s1_last_ff, s1_smooth_ff;
   logic       s1_fwd_ff;
   sample_type s1_fwd_newer_ff, s1_fwd_older_ff;

   logic                          s2_valid_ff;
   logic signed [PROD_A_BITS-1:0] s2_prod_a_ff;
   logic signed [PROD_B_BITS-1:0] s2_prod_b_ff;
   sample_type                    s2_cur_ff, s2_sample_ff;
   frame_type                     s2_frame_ff;
   logic                          s2_first_ff, s2_last_ff, s2_smooth_ff;

   entry_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_BITS-1:0] head_ff, tail_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      phase_ff, phase_in;

   // Accept while the queue has room for every item still in flight
   logic [QUEUE_CNT_BITS-1:0] committed;
   logic                      accept;

   always_comb begin
      committed = count_ff + QUEUE_CNT_BITS'(s1_valid_ff) + QUEUE_CNT_BITS'(s2_valid_ff);
      req.ready = committed < QUEUE_CNT_BITS'(QUEUE_DEPTH);
      accept    = req.valid && req.ready;
   end

   // Frame and pixel counters
   frame_type pix_frame_cur;
   pixel_type pix_cur;
   frame_type frame_ff, frame_in;
   pixel_type pixel_ff, pixel_in;
   logic      is_last;

   always_comb begin
      pix_frame_cur = req.clip_start ? '0 : frame_ff;
      pix_cur       = req.clip_start ? '0 : pixel_ff;
      is_last       = pix_frame_cur >= frame_max;
      frame_in      = frame_ff;
      pixel_in      = pixel_ff;
      if (accept) begin
         if (pix_cur >= pix_max) begin
            pixel_in = '0;
            frame_in = is_last ? '0 : pix_frame_cur + 1'b1;
         end else begin
            pixel_in = pix_cur + 1'b1;
            frame_in = pix_frame_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         pixel_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         pixel_ff <= pixel_in;
      end
   end

   // Frame stores: read at accept, written back from stage 1 in the next cycle
   sample_type older_rd, newer_rd;
   sample_type newer_eff, older_eff;

   always_comb begin
      newer_eff = s1_fwd_ff ? s1_fwd_newer_ff : newer_rd;
      older_eff = s1_fwd_ff ? s1_fwd_older_ff : older_rd;
   end

   tts_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAME_PIXELS)) u_older_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (newer_eff),
      .rd_en   (accept),
      .rd_addr (pix_cur),
      .rd_data (older_rd)
   );

   tts_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_FRAME_PIXELS)) u_newer_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (accept),
      .rd_addr (pix_cur),
      .rd_data (newer_rd)
   );

   // Stage 1: capture the beat, note a same-pixel write still in flight
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff      <= pix_cur;
         s1_sample_ff    <= req.sample_in;
         s1_frame_ff     <= pix_frame_cur;
         s1_first_ff     <= pix_frame_cur != '0;
         s1_last_ff      <= is_last;
         s1_smooth_ff    <= (pix_frame_cur >= FRAME_BITS'(2)) && (frame_max >= FRAME_BITS'(2));
         s1_fwd_ff       <= s1_valid_ff && (s1_addr_ff == pix_cur);
         s1_fwd_newer_ff <= s1_sample_ff;
         s1_fwd_older_ff <= newer_eff;
      end
   end

   // Stage 2: form both weighted products
   logic signed [SAMPLE_BITS:0] pair_sum;

   always_comb begin
      pair_sum = (SAMPLE_BITS+1)'(older_eff) + (SAMPLE_BITS+1)'(s1_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_prod_a_ff <= $signed({1'b0, weight_inv}) * newer_eff;
         s2_prod_b_ff <= $signed({1'b0, weight_eff}) * pair_sum;
         s2_cur_ff    <= newer_eff;
         s2_sample_ff <= s1_sample_ff;
         s2_frame_ff  <= s1_frame_ff;
         s2_first_ff  <= s1_first_ff;
         s2_last_ff   <= s1_last_ff;
         s2_smooth_ff <= s1_smooth_ff;
      end
   end

   // Stage 3: sum, round and build the queue entry
   logic signed [ACC_BITS-1:0] acc;
   entry_type                  push_entry;
   logic                       push;

   always_comb begin
      acc = (ACC_BITS'(s2_prod_a_ff) <<< 1) + ACC_BITS'(s2_prod_b_ff)
            + ACC_BITS'(ONE_Q15);
      push_entry.has_first    = s2_first_ff;
      push_entry.has_last     = s2_last_ff;
      push_entry.first_sample = s2_smooth_ff ? acc[2*WEIGHT_BITS-1:WEIGHT_BITS] : s2_cur_ff;
      push_entry.first_frame  = s2_frame_ff - 1'b1;
      push_entry.last_sample  = s2_sample_ff;
      push_entry.last_frame   = s2_frame_ff;
      push = s2_valid_ff && (s2_first_ff || s2_last_ff);
   end

   // Result queue: one or two beats per entry
   entry_type head;
   logic      emit_first;
   logic      pop;

   always_comb begin
      head           = queue_ff[head_ff];
      emit_first     = head.has_first && !phase_ff;
      rsp.valid      = count_ff != '0;
      rsp.sample_out = emit_first ? head.first_sample : head.last_sample;
      rsp.out_frame  = emit_first ? head.first_frame : head.last_frame;
      rsp.run_last   = emit_first ? !head.has_last : 1'b1;
      pop            = rsp.valid && rsp.ready && (!emit_first || !head.has_last);
      phase_in       = phase_ff;
      if (pop) begin
         phase_in = 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         phase_in = 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         phase_ff <= phase_in;
         if (push) begin
            tail_ff <= tail_ff + 1'b1;
         end
         if (pop) begin
            head_ff <= head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

@@ tb/tts_result_checker.sv @@
// Result checker for the temporal three-tap smoother: predicts and compares every output beat
`timescale 1ns / 1ps
module tts_result_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   tts_req_if                          req,
   tts_rsp_if                          rsp,
   input  wire logic                   csr_write_en,
   input  wire tts_pkg::csr_index_type csr_index,
   input  wire tts_pkg::csr_data_type  csr_data,
   output int                          failure_count,
   output int                          pending_count
);
   import tts_pkg::*;

   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT      = 16'd3277;
   localparam logic [PPF_BITS-1:0]    RESET_PIXEL_COUNT = 13'd4096;
   localparam logic [FPC_BITS-1:0]    RESET_CLIP_SIZE   = 9'd16;
   localparam int                     REPORT_LIMIT      = 10;

   typedef struct packed {
      sample_type sample;
      frame_type  frame;
      logic       tail;
   } out_beat_type;

   out_beat_type due_beats[$];

   // Shadow copies of the two frame stores and the stream position
   sample_type prior_store  [MAX_FRAME_PIXELS];
   sample_type latest_store [MAX_FRAME_PIXELS];
   int         frame_pos;
   int         pixel_pos;

   logic [WEIGHT_BITS-1:0] weight_reg;
   logic [PPF_BITS-1:0]    pixel_count_reg;
   logic [FPC_BITS-1:0]    clip_size_reg;

   // Weighted three-tap blend, rounded to nearest with ties toward plus infinity
   function automatic sample_type blend3(sample_type prev, sample_type cur, sample_type nxt,
                                         int s);
      longint acc;
      acc = 2 * longint'(32768 - s) * longint'(cur)
            + longint'(s) * (longint'(prev) + longint'(nxt)) + 64'sd32768;
      return sample_type'(acc >>> 16);
   endfunction

   // Take one accepted sample: queue the beats it causes and update the stores
   task automatic advance_smoother(input sample_type x, input logic restart);
      int           s;
      int           frame_len;
      int           span;
      int           f;
      int           p;
      logic         is_last;
      sample_type   cur;
      out_beat_type b;
      s         = (weight_reg > ONE_Q15) ? int'(ONE_Q15) : int'(weight_reg);
      frame_len = int'(pixel_count_reg);
      span      = int'(clip_size_reg);
      if (frame_len < 1) frame_len = 1;
      if (frame_len > MAX_FRAME_PIXELS) frame_len = MAX_FRAME_PIXELS;
      if (span < 1) span = 1;
      if (span > MAX_FRAMES) span = MAX_FRAMES;

      if (restart) begin
         frame_pos = 0;
         pixel_pos = 0;
      end
      f       = frame_pos;
      p       = (pixel_pos < MAX_FRAME_PIXELS) ? pixel_pos : MAX_FRAME_PIXELS - 1;
      is_last = (f >= span - 1);

      // Delayed sample of the previous frame: blended only for inner frames
      if (f >= 1) begin
         cur = latest_store[p];
         b.sample = cur;
         if (f >= 2 && span >= 3)
            b.sample = blend3(prior_store[p], cur, x, s);
         b.frame = frame_type'(f - 1);
         b.tail  = !is_last;
         due_beats.insert(due_beats.size(), b);
      end
      // Last frame passes straight through behind it
      if (is_last) begin
         b.sample = x;
         b.frame  = frame_type'(f);
         b.tail   = 1'b1;
         due_beats.insert(due_beats.size(), b);
      end

      prior_store[p]  = latest_store[p];
      latest_store[p] = x;

      // Advance the position, wrapping frame and clip
      if (pixel_pos >= frame_len - 1) begin
         pixel_pos = 0;
         frame_pos = is_last ? 0 : f + 1;
      end else begin
         pixel_pos++;
      end
   endtask

   always @(posedge clock) begin
      out_beat_type want;
      if (reset) begin
         due_beats.delete();
         frame_pos       = 0;
         pixel_pos       = 0;
         weight_reg      = RESET_WEIGHT;
         pixel_count_reg = RESET_PIXEL_COUNT;
         clip_size_reg   = RESET_CLIP_SIZE;
         failure_count   = 0;
      end else begin
         // Compare a result beat with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (due_beats.size() == 0) begin
               failure_count++;
               if (failure_count <= REPORT_LIMIT)
                  $display("unexpected result beat: sample %0d frame %0d last %0b",
                           rsp.sample_out, rsp.out_frame, rsp.run_last);
            end else begin
               want = due_beats.pop_front();
               if (rsp.sample_out !== want.sample || rsp.out_frame !== want.frame ||
                   rsp.run_last !== want.tail) begin
                  failure_count++;
                  if (failure_count <= REPORT_LIMIT)
                     $display("result mismatch: sample %0d/%0d frame %0d/%0d last %0b/%0b",
                              want.sample, rsp.sample_out, want.frame, rsp.out_frame,
                              want.tail, rsp.run_last);
               end
            end
         end
         // Track register writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_SMOOTH_WEIGHT:    weight_reg      = csr_data[WEIGHT_BITS-1:0];
               CSR_PIXELS_PER_FRAME: pixel_count_reg = csr_data[PPF_BITS-1:0];
               CSR_FRAMES_PER_CLIP:  clip_size_reg   = csr_data[FPC_BITS-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            advance_smoother(req.sample_in, req.clip_start);
      end
      pending_count <= due_beats.size();
   end

endmodule

@@ tb/tb_temporal_three_tap_smoother.sv @@
// Testbench top for the temporal three-tap smoother: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_temporal_three_tap_smoother;
   import tts_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_BEATS     = 55;
   localparam int LONG_CLIP_BEATS = 258;
   localparam int MAX_CLIP_BEATS  = 40;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_en;
   csr_index_type csr_index;
   csr_data_type  csr_data;
   int            failure_count;
   int            pending_count;
   int            cycle_count     = 0;
   int            hold_offs_asked = 0;
   logic          steady_sender   = 1'b0;

   tts_req_if req_ch ();
   tts_rsp_if rsp_ch ();

   temporal_three_tap_smoother DUT (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   tts_result_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .failure_count (failure_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return int'($urandom_range(15, 50));
      return int'($urandom_range(1, 3));
   endfunction

   // Random sample with the extremes mixed in
   function automatic sample_type pick_sample();
      int r;
      r = int'($urandom_range(0, 19));
      case (r)
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Offer one beat, after an optional gap, and hold it until taken
   task automatic send_sample(input sample_type value, input logic restart);
      int gap;
      gap = (steady_sender || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.sample_in  <= value;
      req_ch.clip_start <= restart;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Write all three registers, one per cycle
   task automatic configure(input csr_data_type weight, input csr_data_type pixel_count,
                            input csr_data_type clip_size);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SMOOTH_WEIGHT;
      csr_data     <= weight;
      @(posedge clock);
      csr_index    <= CSR_PIXELS_PER_FRAME;
      csr_data     <= pixel_count;
      @(posedge clock);
      csr_index    <= CSR_FRAMES_PER_CLIP;
      csr_data     <= clip_size;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Stop sending, wait for every due beat, then let the pipeline settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Stream clips of random content; some are cut short by an early clip start
   task automatic run_clips(input int frame_len, input int span, input int beats);
      int   clip_beats;
      int   k;
      logic restart;
      restart = 1'b1;
      while (beats > 0) begin
         clip_beats = frame_len * span;
         if (clip_beats > MAX_CLIP_BEATS || $urandom_range(0, 4) == 0)
            clip_beats = $urandom_range(1, (clip_beats > MAX_CLIP_BEATS) ?
                                           MAX_CLIP_BEATS : clip_beats);
         if (clip_beats > beats) clip_beats = beats;
         for (k = 0; k < clip_beats; k++)
            send_sample(pick_sample(), (k == 0) ? restart : 1'b0);
         beats -= clip_beats;
         // Most clips open with a clip start, the rest run on from the wrap
         restart = ($urandom_range(0, 3) != 0);
      end
   endtask

   // Result side: random stalls, steady stretches and the requested long hold-off
   initial begin : receiver
      int   stall_left;
      int   stretch_left;
      int   holds_done;
      logic steady;
      stall_left   = 0;
      stretch_left = 0;
      holds_done   = 0;
      steady       = 1'b0;
      forever begin
         if (holds_done != hold_offs_asked) begin
            // Hold off long enough for the result queue to fill and back up the input
            holds_done = hold_offs_asked;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (stretch_left == 0) begin
               steady       = ($urandom_range(0, 3) == 0);
               stretch_left = $urandom_range(50, 300);
            end
            stretch_left--;
            if (stall_left > 0) begin
               stall_left--;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
               if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int           ph;
      int           frame_len;
      int           span;
      csr_data_type weight;
      csr_data_type ppf_word;
      csr_data_type fpc_word;
      req_ch.valid      <= 1'b0;
      req_ch.sample_in  <= '0;
      req_ch.clip_start <= 1'b0;
      csr_write_en      <= 1'b0;
      csr_index         <= CSR_SMOOTH_WEIGHT;
      csr_data          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: part of an opening frame, nothing due yet
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample('0, 1'b0);
      drain();

      // Shrink the frame under the pixel count so the next beat closes frame 0;
      // full weight, three-frame clip with extreme samples
      configure(ONE_Q15, 16'd2, 16'd3);
      send_sample(16'sd12345, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      drain();

      // Weight above one, then cut the clip below the current frame count
      configure(16'hFFFF, 16'd2, 16'd8);
      for (ph = 0; ph < 8; ph++)
         send_sample(pick_sample(), ph == 0);
      drain();
      configure(16'hFFFF, 16'd2, 16'd3);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      drain();

      // Zero frame size and clip length, then an oversized frame: single-frame clips
      configure('0, '0, '0);
      send_sample('1, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      drain();
      configure(16'd1, 16'hFFFF, 16'd1);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample('0, 1'b0);
      drain();

      // Longest clip at one pixel per frame, wrapping into the next one
      configure(csr_data_type'($urandom_range(0, 32768)), 16'd1, 16'd256);
      for (ph = 0; ph < LONG_CLIP_BEATS; ph++) begin
         if (ph == 20) hold_offs_asked++;
         send_sample(pick_sample(), ph == 0);
      end
      drain();

      // Random settings, mostly small frames and short clips
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 9))
            0:       weight = '0;
            1:       weight = ONE_Q15;
            2:       weight = csr_data_type'($urandom_range(32769, 65535));
            default: weight = csr_data_type'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 9))
            0:       ppf_word = '0;
            1:       ppf_word = csr_data_type'($urandom_range(4096, 8191));
            default: ppf_word = csr_data_type'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       fpc_word = '0;
            1:       fpc_word = csr_data_type'($urandom_range(7, 511));
            default: fpc_word = csr_data_type'($urandom_range(1, 6));
         endcase
         // Big frames get one-frame clips so results keep flowing
         if (ppf_word > 6) fpc_word = csr_data_type'($urandom_range(0, 1));
         frame_len = (ppf_word == 0) ? 1 :
                     (ppf_word > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : int'(ppf_word);
         span      = (fpc_word == 0) ? 1 :
                     (fpc_word > MAX_FRAMES) ? MAX_FRAMES : int'(fpc_word);
         configure(weight, ppf_word, fpc_word);
         steady_sender = ($urandom_range(0, 3) == 0);
         run_clips(frame_len, span, PHASE_BEATS);
         drain();
      end

      if (failure_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
